// ===== src/tdpt_pkg.sv =====
// Shared types and constants for the trial-division prime test.
// No dependencies; used by the top level and by its checker.
package tdpt_pkg;

    typedef logic [1:0] verdict_t;

    localparam verdict_t VERDICT_PRIME     = 2'd0;
    localparam verdict_t VERDICT_COMPOSITE = 2'd1;
    localparam verdict_t VERDICT_ONE       = 2'd2;
    localparam verdict_t VERDICT_NEGATIVE  = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_CHECK,
        ST_DONE
    } state_t;

endpackage

// ===== src/trial_division_prime_test.sv =====
// Trial-division prime test: one shared restoring divider, one quotient bit per cycle.
// Negative numbers, zero and one are classified at the input and skip the divider;
// other numbers are tried against each candidate divisor, up to floor(sqrt(n)) candidates.
// One transaction at a time: in_ready stays low until the result is handed on; output stalls add.
// Reset (rst_n, async, active low) idles the sequencer and empties the output register.
// Depends on tdpt_pkg.
module trial_division_prime_test #(
    parameter int NUMBER_WIDTH = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic signed [NUMBER_WIDTH-1:0] number,
    output logic                           out_valid,
    input  logic                           out_ready,
    output tdpt_pkg::verdict_t             verdict
);

    localparam int W      = NUMBER_WIDTH;
    localparam int CNT_W  = $clog2(W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(W - 1);

    tdpt_pkg::state_t state_reg, state_next;

    logic [W-1:0]       n_reg;      // number under test
    logic [W-1:0]       d_reg;      // candidate divisor
    logic [W-1:0]       quo_reg;    // dividend bits out, quotient bits in
    logic [W-1:0]       rem_reg;
    logic [CNT_W-1:0]   cnt_reg;
    tdpt_pkg::verdict_t verdict_reg;
    logic               out_valid_reg;
    tdpt_pkg::verdict_t out_verdict_reg;

    logic               accept;
    logic               special;
    tdpt_pkg::verdict_t special_verdict;
    logic               div_active;
    logic               load_out;
    logic               out_free;
    logic               cnt_done;
    logic [W:0]         rem_shift;
    logic [W:0]         diff;
    logic               fits;
    logic               q_small;
    logic               r_zero;

    assign accept   = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;
    assign cnt_done = (cnt_reg == CNT_LAST);

    // Shortcut classes decided at the input
    always_comb
    begin
        special         = 1'b1;
        special_verdict = tdpt_pkg::VERDICT_NEGATIVE;
        if (number[W-1])
            special_verdict = tdpt_pkg::VERDICT_NEGATIVE;
        else if (number == '0)
            special_verdict = tdpt_pkg::VERDICT_COMPOSITE;
        else if (number == W'(1))
            special_verdict = tdpt_pkg::VERDICT_ONE;
        else
            special = 1'b0;
    end

    // Shared divider step
    assign rem_shift = {rem_reg, quo_reg[W-1]};
    assign diff      = rem_shift - {1'b0, d_reg};
    assign fits      = !diff[W];

    // Stop once n/d < d; otherwise an exact division means composite
    assign q_small = (quo_reg < d_reg);
    assign r_zero  = (rem_reg == '0);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            tdpt_pkg::ST_IDLE:
            begin
                if (in_valid)
                    state_next = special ? tdpt_pkg::ST_DONE : tdpt_pkg::ST_DIVIDE;
            end
            tdpt_pkg::ST_DIVIDE:
            begin
                if (cnt_done)
                    state_next = tdpt_pkg::ST_CHECK;
            end
            tdpt_pkg::ST_CHECK:
            begin
                if (q_small || r_zero)
                    state_next = tdpt_pkg::ST_DONE;
                else
                    state_next = tdpt_pkg::ST_DIVIDE;
            end
            tdpt_pkg::ST_DONE:
            begin
                if (out_free)
                    state_next = tdpt_pkg::ST_IDLE;
            end
            default: state_next = tdpt_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready   = 1'b0;
        div_active = 1'b0;
        load_out   = 1'b0;
        unique case (state_reg)
            tdpt_pkg::ST_IDLE:   in_ready   = 1'b1;
            tdpt_pkg::ST_DIVIDE: div_active = 1'b1;
            tdpt_pkg::ST_CHECK:  ;
            tdpt_pkg::ST_DONE:   load_out   = out_free;
            default:             ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tdpt_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            n_reg       <= number;
            d_reg       <= W'(2);
            quo_reg     <= number;
            rem_reg     <= '0;
            cnt_reg     <= '0;
            verdict_reg <= special_verdict;
        end
        else if (div_active)
        begin
            quo_reg <= {quo_reg[W-2:0], fits};
            rem_reg <= fits ? diff[W-1:0] : rem_shift[W-1:0];
            cnt_reg <= cnt_reg + CNT_W'(1);
        end
        else if (state_reg == tdpt_pkg::ST_CHECK)
        begin
            if (q_small)
                verdict_reg <= tdpt_pkg::VERDICT_PRIME;
            else if (r_zero)
                verdict_reg <= tdpt_pkg::VERDICT_COMPOSITE;
            d_reg   <= d_reg + W'(1);
            quo_reg <= n_reg;
            rem_reg <= '0;
            cnt_reg <= '0;
        end

        if (load_out)
            out_verdict_reg <= verdict_reg;
    end

    assign out_valid = out_valid_reg;
    assign verdict   = out_verdict_reg;

endmodule

// ===== src/tdpt_checker.sv =====
// Port-level checker for trial_division_prime_test, with its bind statement.
// Depends on tdpt_pkg and on the top level's port names.
module tdpt_checker #(
    parameter int NUMBER_WIDTH = 32
) (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           in_valid,
    input logic                           in_ready,
    input logic signed [NUMBER_WIDTH-1:0] number,
    input logic                           out_valid,
    input logic                           out_ready,
    input tdpt_pkg::verdict_t             verdict
);

    // A stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(verdict))
        else $error("result changed while stalled");

    // Busy after each transaction
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken while busy");

    // Negative input short-circuits to the error code
    a_negative: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && number[NUMBER_WIDTH-1] && !out_valid
        |-> ##2 (out_valid && verdict == tdpt_pkg::VERDICT_NEGATIVE))
        else $error("negative input not flagged");

    // One gets its own code
    a_one: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && number == NUMBER_WIDTH'(1) && !out_valid
        |-> ##2 (out_valid && verdict == tdpt_pkg::VERDICT_ONE))
        else $error("one not flagged");

endmodule

bind trial_division_prime_test tdpt_checker #(.NUMBER_WIDTH(NUMBER_WIDTH)) u_tdpt_checker (.*);
